// ----- rtl/core/trmb_pkg.sv -----
// ----------------------------------------------------------------------------
// trmb_pkg: shared types and constants of the trimmed-mean 3x3 RGB filter
// Pixel word layouts, line memory sizing, result queue sizing and the
// reciprocal used to divide the trimmed channel sums by seven.
// ----------------------------------------------------------------------------
package trmb_pkg;

    // image geometry
    localparam int MAX_SIZE = 1024;
    localparam int ADDR_W   = $clog2(MAX_SIZE);
    localparam int COORD_W  = 10;
    localparam int SIZE_W   = 11;
    localparam int SIZE_MIN = 3;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd512;

    // pixel words: red in the top byte, blue in the bottom byte
    localparam int CHAN_W = 8;
    localparam int PIX_W  = 3 * CHAN_W;
    localparam int LUM_W  = 10;
    localparam int SUM_W  = 12;
    localparam int TRIM_W = 11;

    // divide by seven as (x * 2341) >> 14, exact for x up to 7 * 255
    localparam int RECIP_7     = 2341;
    localparam int RECIP_W     = 12;
    localparam int RECIP_SHIFT = 14;
    localparam int PROD_W      = TRIM_W + RECIP_W;

    // result queue
    localparam int QUEUE_DEPTH = 16;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // result slots of one input word, in the order they leave
    localparam int EMIT_W     = 4;
    localparam int EMIT_LEFT  = 0;  // left border pixel of the row above
    localparam int EMIT_FILT  = 1;  // filtered pixel of the row above
    localparam int EMIT_RIGHT = 2;  // right border pixel of the row above
    localparam int EMIT_OWN   = 3;  // the input pixel itself (top or bottom row)

    typedef struct packed {
        logic [CHAN_W-1:0] red_in;
        logic [CHAN_W-1:0] green_in;
        logic [CHAN_W-1:0] blue_in;
    } pix_in_t;

    typedef struct packed {
        logic [CHAN_W-1:0]  red_out;
        logic [CHAN_W-1:0]  green_out;
        logic [CHAN_W-1:0]  blue_out;
        logic [COORD_W-1:0] out_row;
        logic [COORD_W-1:0] out_col;
        logic               last_of_run;
    } pix_out_t;

    // fields that travel beside the filter arithmetic
    typedef struct packed {
        logic [PIX_W-1:0]  px;
        logic [PIX_W-1:0]  brd;
        logic [ADDR_W-1:0] row;
        logic [ADDR_W-1:0] col;
        logic [EMIT_W-1:0] emit;
    } side_t;

    // one queue entry: every result one input word can cause
    typedef struct packed {
        logic [PIX_W-1:0] filt;
        side_t            side;
    } bundle_t;

    // intensity candidate for the darkest and brightest search
    typedef struct packed {
        logic [LUM_W-1:0] lum;
        logic [3:0]       idx;
    } cand_t;

endpackage

// ----- rtl/core/trimmed_blur_3x3_rgb.sv -----
// ----------------------------------------------------------------------------
// trimmed_blur_3x3_rgb: streaming 3x3 trimmed-mean filter for RGB images
// Line memory, 3x3 window, filter pipeline and result queue with unpacker.
// ----------------------------------------------------------------------------
// Pixels of a square image enter in raster order at one word per cycle.
// For each interior pixel the nine window pixels are ranked by r+g+b, the
// darkest (last on ties) and brightest (first on ties) are dropped and each
// channel of the other seven is averaged, truncating. Border pixels pass
// through unchanged; every result carries its row and column, and
// last_of_run marks the final result caused by an input word. The two
// previous rows live in one 1024 x 48 line memory, read when a word is taken
// and written back in the next cycle; no clearing pass is needed after reset.
// An input word passes the stage 1 to 4 registers, the result queue and the
// output register; a new word can be taken every cycle while s_ready is high.
// Results leave one per cycle while m_ready is high from a 16-entry queue, so
// row ends and the bottom row (up to three results per word) slow the input
// once the queue fills. image_size must be written only while the block is
// idle; the block does not enforce it. The write restarts at row 0, column 0.
module trimmed_blur_3x3_rgb
    import trmb_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [SIZE_W-1:0] cfg_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  pix_in_t           s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output pix_out_t          m_data
);

    localparam int EFF_W  = ADDR_W + 1;
    localparam int LINE_W = 2 * PIX_W;
    localparam int CNT_W  = QPTR_W + 2;

    function automatic logic [LUM_W-1:0] lum_of(input logic [PIX_W-1:0] p);
        return LUM_W'(p[23:16]) + LUM_W'(p[15:8]) + LUM_W'(p[7:0]);
    endfunction

    // later candidate wins ties for the darkest
    function automatic cand_t pick_min(input cand_t a, input cand_t b);
        return (b.lum <= a.lum) ? b : a;
    endfunction

    // earlier candidate wins ties for the brightest
    function automatic cand_t pick_max(input cand_t a, input cand_t b);
        return (b.lum > a.lum) ? b : a;
    endfunction

    // ---------------- configuration and position ----------------
    logic [SIZE_W-1:0] size_reg;
    logic [ADDR_W-1:0] row_reg, row_next;
    logic [ADDR_W-1:0] col_reg, col_next;
    logic [EFF_W-1:0]  eff_size;
    logic [ADDR_W-1:0] last_idx;
    logic              s_accept;
    logic              cfg_accept;
    logic [EMIT_W-1:0] emit_in;
    logic              row_deep;

    // ---------------- stage 1: line memory read ----------------
    logic [LINE_W-1:0] line_mem [MAX_SIZE];
    logic [LINE_W-1:0] line_rd_reg;
    logic              st1_valid_reg;
    logic [PIX_W-1:0]  st1_px_reg;
    logic [ADDR_W-1:0] st1_row_reg;
    logic [ADDR_W-1:0] st1_col_reg;
    logic [EMIT_W-1:0] st1_emit_reg;
    logic [PIX_W-1:0]  top_pix;
    logic [PIX_W-1:0]  mid_pix;
    logic [PIX_W-1:0]  win_reg [3][2];
    logic [PIX_W-1:0]  nine_pix [9];
    side_t             side1;

    // ---------------- stage 2: ranking and sums ----------------
    logic              st2_valid_reg;
    side_t             st2_side_reg;
    logic [PIX_W-1:0]  st2_pix_reg [9];
    logic [LUM_W-1:0]  st2_lum_reg [9];
    cand_t             leaf [9];
    cand_t             mn1 [4];
    cand_t             mx1 [4];
    cand_t             mn2 [2];
    cand_t             mx2 [2];
    cand_t             mn3, mx3, mn4, mx4;
    logic [SUM_W-1:0]  sum2 [3];

    // ---------------- stage 3: trim ----------------
    logic              st3_valid_reg;
    side_t             st3_side_reg;
    logic [SUM_W-1:0]  st3_sum_reg [3];
    logic [PIX_W-1:0]  st3_min_reg;
    logic [PIX_W-1:0]  st3_max_reg;
    logic [SUM_W-1:0]  trim_full [3];

    // ---------------- stage 4: divide by seven ----------------
    logic              st4_valid_reg;
    side_t             st4_side_reg;
    logic [TRIM_W-1:0] st4_trim_reg [3];
    logic [PROD_W-1:0] prod [3];
    logic [PIX_W-1:0]  filt_pix;

    // ---------------- result queue and unpacker ----------------
    bundle_t           queue_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   q_count_reg;
    logic [EMIT_W-1:0] sent_reg;
    logic              push;
    logic              pop;
    logic [2:0]        inflight;
    bundle_t           head;
    logic [EMIT_W-1:0] left_mask;
    logic [EMIT_W-1:0] sel;
    logic [EMIT_W-1:0] rest;
    logic              out_load;
    logic              m_valid_reg;
    pix_out_t          m_data_reg;
    pix_out_t          result;
    logic [PIX_W-1:0]  res_pix;

    // effective size and last index
    always_comb begin
        if (size_reg < SIZE_W'(SIZE_MIN)) begin
            eff_size = EFF_W'(SIZE_MIN);
        end else if (32'(size_reg) > MAX_SIZE) begin
            eff_size = EFF_W'(MAX_SIZE);
        end else begin
            eff_size = EFF_W'(size_reg);
        end
        last_idx = ADDR_W'(eff_size - EFF_W'(1));
    end

    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid;
    assign s_accept   = s_valid && s_ready;

    // result slots caused by the word at the current position
    always_comb begin
        row_deep            = row_reg >= ADDR_W'(2);
        emit_in             = '0;
        emit_in[EMIT_LEFT]  = row_deep && (col_reg == ADDR_W'(1));
        emit_in[EMIT_FILT]  = row_deep && (col_reg >= ADDR_W'(2));
        emit_in[EMIT_RIGHT] = row_deep && (col_reg == last_idx);
        emit_in[EMIT_OWN]   = (row_reg == '0) || (row_reg == last_idx);
    end

    // raster position of the next word
    always_comb begin
        row_next = row_reg;
        col_next = col_reg;
        if (cfg_accept) begin
            row_next = '0;
            col_next = '0;
        end else if (s_accept) begin
            if (col_reg == last_idx) begin
                col_next = '0;
                row_next = (row_reg == last_idx) ? '0 : row_reg + ADDR_W'(1);
            end else begin
                col_next = col_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= SIZE_RESET;
            row_reg  <= '0;
            col_reg  <= '0;
        end else begin
            if (cfg_accept) begin
                size_reg <= cfg_data;
            end
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // line memory: read on accept, write back the shifted column in stage 1
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            line_rd_reg <= line_mem[col_reg];
        end
        if (st1_valid_reg) begin
            line_mem[st1_col_reg] <= {mid_pix, st1_px_reg};
        end
    end

    // stage 1 registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else begin
            st1_valid_reg <= s_accept;
        end
        if (s_accept) begin
            st1_px_reg   <= {s_data.red_in, s_data.green_in, s_data.blue_in};
            st1_row_reg  <= row_reg;
            st1_col_reg  <= col_reg;
            st1_emit_reg <= emit_in;
        end
    end

    assign top_pix = line_rd_reg[LINE_W-1:PIX_W];
    assign mid_pix = line_rd_reg[PIX_W-1:0];

    // window columns shift as each word passes stage 1
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                win_reg[i][0] <= '0;
                win_reg[i][1] <= '0;
            end
        end else if (st1_valid_reg) begin
            win_reg[0][0] <= win_reg[0][1];
            win_reg[0][1] <= top_pix;
            win_reg[1][0] <= win_reg[1][1];
            win_reg[1][1] <= mid_pix;
            win_reg[2][0] <= win_reg[2][1];
            win_reg[2][1] <= st1_px_reg;
        end
    end

    // 3x3 neighborhood in scan order
    always_comb begin
        nine_pix[0] = win_reg[0][0];
        nine_pix[1] = win_reg[0][1];
        nine_pix[2] = top_pix;
        nine_pix[3] = win_reg[1][0];
        nine_pix[4] = win_reg[1][1];
        nine_pix[5] = mid_pix;
        nine_pix[6] = win_reg[2][0];
        nine_pix[7] = win_reg[2][1];
        nine_pix[8] = st1_px_reg;
        side1.px    = st1_px_reg;
        side1.brd   = st1_emit_reg[EMIT_LEFT] ? win_reg[1][1] : mid_pix;
        side1.row   = st1_row_reg;
        side1.col   = st1_col_reg;
        side1.emit  = st1_emit_reg;
    end

    // stage 2 registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st2_valid_reg <= 1'b0;
        end else begin
            st2_valid_reg <= st1_valid_reg;
        end
        if (st1_valid_reg) begin
            st2_side_reg <= side1;
            for (int k = 0; k < 9; k++) begin
                st2_pix_reg[k] <= nine_pix[k];
                st2_lum_reg[k] <= lum_of(nine_pix[k]);
            end
        end
    end

    // darkest and brightest by a four-level tournament
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            leaf[k].lum = st2_lum_reg[k];
            leaf[k].idx = 4'(k);
        end
        for (int k = 0; k < 4; k++) begin
            mn1[k] = pick_min(leaf[2*k], leaf[2*k+1]);
            mx1[k] = pick_max(leaf[2*k], leaf[2*k+1]);
        end
        for (int k = 0; k < 2; k++) begin
            mn2[k] = pick_min(mn1[2*k], mn1[2*k+1]);
            mx2[k] = pick_max(mx1[2*k], mx1[2*k+1]);
        end
        mn3 = pick_min(mn2[0], mn2[1]);
        mx3 = pick_max(mx2[0], mx2[1]);
        mn4 = pick_min(mn3, leaf[8]);
        mx4 = pick_max(mx3, leaf[8]);
    end

    // per-channel sums of the nine pixels
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            sum2[ch] = '0;
            for (int k = 0; k < 9; k++) begin
                sum2[ch] = sum2[ch] + SUM_W'(st2_pix_reg[k][(2-ch)*CHAN_W +: CHAN_W]);
            end
        end
    end

    // stage 3 registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st3_valid_reg <= 1'b0;
        end else begin
            st3_valid_reg <= st2_valid_reg;
        end
        if (st2_valid_reg) begin
            st3_side_reg <= st2_side_reg;
            st3_min_reg  <= st2_pix_reg[mn4.idx];
            st3_max_reg  <= st2_pix_reg[mx4.idx];
            for (int ch = 0; ch < 3; ch++) begin
                st3_sum_reg[ch] <= sum2[ch];
            end
        end
    end

    // drop darkest and brightest, at most 7 * 255 remains
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            trim_full[ch] = st3_sum_reg[ch]
                - SUM_W'(st3_min_reg[(2-ch)*CHAN_W +: CHAN_W])
                - SUM_W'(st3_max_reg[(2-ch)*CHAN_W +: CHAN_W]);
        end
    end

    // stage 4 registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st4_valid_reg <= 1'b0;
        end else begin
            st4_valid_reg <= st3_valid_reg;
        end
        if (st3_valid_reg) begin
            st4_side_reg <= st3_side_reg;
            for (int ch = 0; ch < 3; ch++) begin
                st4_trim_reg[ch] <= trim_full[ch][TRIM_W-1:0];
            end
        end
    end

    // divide by seven through the reciprocal
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            prod[ch] = PROD_W'(st4_trim_reg[ch]) * PROD_W'(RECIP_7);
            filt_pix[(2-ch)*CHAN_W +: CHAN_W] = prod[ch][RECIP_SHIFT +: CHAN_W];
        end
    end

    // queue bookkeeping; words with no result are not queued
    assign push     = st4_valid_reg && (st4_side_reg.emit != '0);
    assign inflight = 3'(st1_valid_reg) + 3'(st2_valid_reg)
                    + 3'(st3_valid_reg) + 3'(st4_valid_reg);
    assign s_ready  = (CNT_W'(q_count_reg) + CNT_W'(inflight)) < CNT_W'(QUEUE_DEPTH);

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_mem[wr_ptr_reg] <= '{filt: filt_pix, side: st4_side_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            q_count_reg <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                q_count_reg <= q_count_reg + (QPTR_W+1)'(1);
            end else if (pop && !push) begin
                q_count_reg <= q_count_reg - (QPTR_W+1)'(1);
            end
        end
    end

    // pick the next unsent slot of the head entry
    always_comb begin
        head      = queue_mem[rd_ptr_reg];
        left_mask = head.side.emit & ~sent_reg;
        sel       = left_mask & (~left_mask + EMIT_W'(1));
        rest      = left_mask & ~sel;
        out_load  = (q_count_reg != '0) && (!m_valid_reg || m_ready);
        pop       = out_load && (rest == '0);
    end

    // build the result word for the selected slot
    always_comb begin
        result.out_row = COORD_W'(head.side.row - ADDR_W'(1));
        result.out_col = COORD_W'(head.side.col);
        res_pix        = head.side.brd;
        priority if (sel[EMIT_LEFT]) begin
            result.out_col = '0;
        end else if (sel[EMIT_FILT]) begin
            res_pix        = head.filt;
            result.out_col = COORD_W'(head.side.col - ADDR_W'(1));
        end else if (sel[EMIT_RIGHT]) begin
            res_pix        = head.side.brd;
        end else begin
            res_pix        = head.side.px;
            result.out_row = COORD_W'(head.side.row);
        end
        result.red_out     = res_pix[23:16];
        result.green_out   = res_pix[15:8];
        result.blue_out    = res_pix[7:0];
        result.last_of_run = (rest == '0);
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            sent_reg    <= '0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
            sent_reg    <= (rest == '0) ? '0 : (sent_reg | sel);
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (out_load) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTH
    // queue never written while full unless an entry leaves at once
    a_queue_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (q_count_reg < (QPTR_W+1)'(QUEUE_DEPTH)) || pop)
        else $error("result queue overflow");

    // line memory read and write-back never hit the same entry together
    a_line_hazard: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && st1_valid_reg) |-> (col_reg != st1_col_reg))
        else $error("line memory read collides with write-back");

    // an empty block always takes a word
    a_idle_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        ((q_count_reg == '0) && (inflight == '0)) |-> s_ready)
        else $error("idle block refuses input");
`endif

endmodule
